/* hw/rtl/qtl_pkg.sv */
`timescale 1ns / 1ps

package qtl_pkg;

  // Default build of the logger.
  localparam int CHANNELS_DEFAULT   = 4;
  localparam int RING_DEPTH_DEFAULT = 256;

  // Idle timeout after reset: 50 MHz timer, 3/125 of a second.
  localparam logic [31:0] IDLE_TIMEOUT_RESET = 32'(50 * 1000000 * 3 / 125);

  // Field widths.
  localparam int CHAN_W  = 2;
  localparam int PHASE_W = 2;
  localparam int TIME_W  = 32;
  localparam int POS_W   = 32;
  localparam int SLOT_OUT_W = 8;

  typedef logic [PHASE_W-1:0] phase_t;

  // Next phase when counting up: 0-2-3-1-0.
  function automatic phase_t fwd_next(input phase_t prev);
    phase_t nxt;
    unique case (prev)
      2'd0: nxt = 2'd2;
      2'd1: nxt = 2'd0;
      2'd2: nxt = 2'd3;
      2'd3: nxt = 2'd1;
      default: nxt = 2'd0;
    endcase
    return nxt;
  endfunction

  // Next phase when counting down: 0-1-3-2-0.
  function automatic phase_t rev_next(input phase_t prev);
    phase_t nxt;
    unique case (prev)
      2'd0: nxt = 2'd1;
      2'd1: nxt = 2'd3;
      2'd2: nxt = 2'd0;
      2'd3: nxt = 2'd2;
      default: nxt = 2'd0;
    endcase
    return nxt;
  endfunction

endpackage

/* hw/rtl/quadrature_tacho_logger.sv */
`timescale 1ns / 1ps

// Quadrature decoder with position logging for several encoder channels.
// Input stream: one phase sample per item. s_axis_tuser carries the channel,
// s_axis_tdata the sampled phase bits and the timer value at sampling.
// Output stream: one log record per item that moved the count or whose
// channel has been idle for longer than the programmed timeout. The
// record carries the channel, the next ring slot, the position and time.
// Items that log nothing are consumed silently.
// Throughput: one item per clock while the input side is not stopped. An
// accepted item is held in an input register and its record is then loaded
// into the output register, from which the receiver takes it; the per-channel
// state update, a 32-bit increment or decrement, a 32-bit subtract and a
// 32-bit compare sit between the input and output registers.
// When the receiver stalls, the record is held in the output register; the
// input register still drains items that log nothing, and the input side
// stops only when a second record would be needed.
// Reset (rst, synchronous) clears all channel state to zero, empties both
// registers and loads the default idle timeout. cfg_we/cfg_wdata rewrite the
// timeout; the user must write it only while the block is idle; not enforced.

module quadrature_tacho_logger #(
  parameter int CHANNELS   = qtl_pkg::CHANNELS_DEFAULT,
  parameter int RING_DEPTH = qtl_pkg::RING_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: idle_timeout_ticks.
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  // Input samples.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // phase_state[1:0], now_time[33:2], zeros
  input  logic [1:0]  s_axis_tuser,  // channel[1:0]
  // Log records.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // log_slot[7:0], log_position[39:8],
                                     // log_time[71:40]
  output logic [1:0]  m_axis_tuser   // log_channel[1:0]
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

  // Configuration register.
  logic [31:0] idle_timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= qtl_pkg::IDLE_TIMEOUT_RESET;
    end else if (cfg_we) begin
      idle_timeout <= cfg_wdata;
    end
  end

  // Per-channel state.
  qtl_pkg::phase_t                last_phase    [CHANNELS];
  logic [qtl_pkg::POS_W-1:0]      position_count[CHANNELS];
  logic [qtl_pkg::TIME_W-1:0]     last_log_time [CHANNELS];
  logic [SLOT_W-1:0]              write_slot    [CHANNELS];

  // Input register.
  logic                           s1_valid;
  logic [qtl_pkg::CHAN_W-1:0]     s1_channel;
  qtl_pkg::phase_t                s1_phase;
  logic [qtl_pkg::TIME_W-1:0]     s1_time;

  // Decode of the registered item.
  logic [CH_W-1:0]                s1_idx;
  logic                           s1_ch_ok;
  qtl_pkg::phase_t                prev_phase;
  logic                           step_up;
  logic                           step_down;
  logic                           moved;
  logic [qtl_pkg::POS_W-1:0]      pos_next;
  logic [qtl_pkg::TIME_W-1:0]     elapsed;
  logic                           emit;
  logic [SLOT_W-1:0]              slot_next;
  logic [31:0]                    slot_wide;
  logic                           out_free;
  logic                           s1_fire;

  always_comb begin
    s1_idx     = CH_W'(s1_channel);
    s1_ch_ok   = (32'(s1_channel) < 32'(CHANNELS));
    prev_phase = s1_ch_ok ? last_phase[s1_idx] : '0;
    step_up    = (s1_phase == qtl_pkg::fwd_next(prev_phase));
    step_down  = (s1_phase == qtl_pkg::rev_next(prev_phase));
    moved      = step_up || step_down;
    pos_next   = s1_ch_ok ? position_count[s1_idx] : '0;
    if (step_up) begin
      pos_next = pos_next + 1'b1;
    end else if (step_down) begin
      pos_next = pos_next - 1'b1;
    end
    elapsed    = s1_time - (s1_ch_ok ? last_log_time[s1_idx] : '0);
    emit       = s1_ch_ok && (moved || (elapsed > idle_timeout));
    slot_next  = s1_ch_ok ? write_slot[s1_idx] : '0;
    slot_next  = (slot_next == SLOT_LAST) ? '0 : slot_next + 1'b1;
    slot_wide  = 32'(slot_next);
  end

  // Handshake: the input register empties unless its record finds the
  // output register still occupied.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_fire       = s1_valid && (!emit || out_free);
  assign s_axis_tready = !s1_valid || s1_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_channel <= s_axis_tuser;
      s1_phase   <= s_axis_tdata[1:0];
      s1_time    <= s_axis_tdata[33:2];
    end
  end

  // Channel state update when the registered item completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_phase[i]     <= '0;
        position_count[i] <= '0;
        last_log_time[i]  <= '0;
        write_slot[i]     <= '0;
      end
    end else if (s1_fire && s1_ch_ok) begin
      last_phase[s1_idx]     <= s1_phase;
      position_count[s1_idx] <= pos_next;
      if (emit) begin
        write_slot[s1_idx]    <= slot_next;
        last_log_time[s1_idx] <= s1_time;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_fire && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      m_axis_tuser  <= s1_channel;
      m_axis_tdata  <= {s1_time, pos_next, slot_wide[qtl_pkg::SLOT_OUT_W-1:0]};
    end
  end

  // A waiting record always matches its channel's current state: items that
  // slip past it can neither move the count nor restart the idle time.
  logic [CH_W-1:0] out_idx;
  logic [31:0]     out_slot_wide;

  assign out_idx       = CH_W'(m_axis_tuser);
  assign out_slot_wide = 32'(write_slot[out_idx]);

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    s1_fire && emit |=> m_axis_tvalid)
    else $error("record lost between input and output register");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> s1_valid && emit && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a pending record");

  a_pos_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> position_count[out_idx] == m_axis_tdata[39:8] &&
                      last_log_time[out_idx] == m_axis_tdata[71:40])
    else $error("waiting record disagrees with channel state");

  a_slot_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_slot_wide[qtl_pkg::SLOT_OUT_W-1:0] == m_axis_tdata[7:0])
    else $error("waiting record slot disagrees with channel slot");

endmodule
